/* rtl/mrsp_pkg.sv */
// ----------------------------------------------------------------------------
// mrsp_pkg: shared types and constants of the metadata reply stream parser
// Holds the parse phases, token and outcome codes, reply types and the
// token record that travels from the parser core to the output queue.
// ----------------------------------------------------------------------------
package mrsp_pkg;

  // Where the parser stands inside a reply.
  typedef enum logic [3:0] {
    PH_HEADER  = 4'd0,
    PH_SKIP    = 4'd1,
    PH_STCOUNT = 4'd2,
    PH_STATUS  = 4'd3,
    PH_FNCOUNT = 4'd4,
    PH_NAME    = 4'd5,
    PH_FLEN    = 4'd6,
    PH_DLEN    = 4'd7,
    PH_DATA    = 4'd8,
    PH_POP     = 4'd9
  } phase_e;

  // Token kinds carried on the result stream.
  typedef enum logic [3:0] {
    TK_ST_COUNT = 4'd0,
    TK_STATUS   = 4'd1,
    TK_FN_COUNT = 4'd2,
    TK_NAME     = 4'd3,
    TK_NAME_END = 4'd4,
    TK_FN_LEN   = 4'd5,
    TK_DATA_LEN = 4'd6,
    TK_DATA     = 4'd7,
    TK_POP      = 4'd8,
    TK_END      = 4'd9
  } tk_e;

  // Outcome reported with the message end token.
  typedef enum logic [1:0] {
    OC_OK       = 2'd0,
    OC_BAD_TYPE = 2'd1,
    OC_TRUNC    = 2'd2
  } oc_e;

  // Expected reply kind, as written to the configuration register.
  typedef enum logic [1:0] {
    RK_HELLO = 2'd0,
    RK_PUSH  = 2'd1,
    RK_PULL  = 2'd2
  } rk_e;

  localparam rk_e RK_RESET = RK_PULL;

  // Reply type bytes.
  localparam logic [7:0] TYPE_HELLO_A = 8'h0a;
  localparam logic [7:0] TYPE_HELLO_B = 8'h31;
  localparam logic [7:0] TYPE_PUSH    = 8'h11;
  localparam logic [7:0] TYPE_PULL    = 8'h0f;

  // Number of length bytes that open the header; the type byte follows them.
  localparam logic [2:0] HDR_LEN_BYTES = 3'd4;

  // Output queue depth; must hold at least two results beyond the one on show.
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned OUT_AW    = $clog2(OUT_DEPTH);

  // Padded stream data width: value and outcome, rounded up to bytes.
  localparam int unsigned TDATA_W = 40;

  typedef struct packed {
    tk_e         kind;
    logic [31:0] value;
    oc_e         outcome;
    logic        last;
  } tok_t;

  // Results produced by one accepted byte: zero, one or two tokens.
  typedef struct packed {
    logic [1:0] count;
    tok_t       tok0;
    tok_t       tok1;
  } res_t;

endpackage

/* rtl/mrsp_parser.sv */
// ----------------------------------------------------------------------------
// mrsp_parser: reply parser core
// Holds the reply state and turns each accepted byte combinationally into
// zero, one or two tokens.
// ----------------------------------------------------------------------------
module mrsp_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_wdata_i,
  input  logic                 byte_fire_i,
  input  logic [7:0]           byte_i,
  output mrsp_pkg::res_t       res_o
);

  mrsp_pkg::rk_e    kind_q;
  mrsp_pkg::phase_e phase_q, phase_d;
  logic [2:0]       hdr_cnt_q, hdr_cnt_d;
  logic [31:0]      plen_q, plen_d;
  logic [7:0]       mtype_q, mtype_d;
  logic [2:0]       dd_cnt_q, dd_cnt_d;
  logic [31:0]      dd_acc_q, dd_acc_d;
  logic [31:0]      sts_q, sts_d;
  logic [31:0]      fns_q, fns_d;
  logic [31:0]      dlen_q, dlen_d;
  mrsp_pkg::oc_e    err_q, err_d;

  // Packed integer decoder, next values.
  logic [2:0]  dd_cnt_n;
  logic [31:0] dd_acc_n;
  logic [31:0] dd_val;
  logic        dd_done;

  logic              type_ok;
  logic              fin;
  logic              have_tok;
  mrsp_pkg::tok_t    tok;
  mrsp_pkg::tok_t    end_tok;
  mrsp_pkg::oc_e     oc;
  mrsp_pkg::phase_e  after_sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= mrsp_pkg::RK_RESET;
    end else if (cfg_we_i) begin
      kind_q <= mrsp_pkg::rk_e'(cfg_wdata_i);
    end
  end

  always_comb begin
    dd_cnt_n = dd_cnt_q;
    dd_acc_n = dd_acc_q;
    dd_val   = 32'd0;
    dd_done  = 1'b0;
    if (dd_cnt_q == 3'd0) begin
      if (!byte_i[7]) begin
        dd_val  = {24'd0, byte_i};
        dd_done = 1'b1;
      end else if (byte_i[6] == 1'b0) begin
        dd_acc_n = {26'd0, byte_i[5:0]};
        dd_cnt_n = 3'd1;
      end else if (byte_i == 8'hFF) begin
        dd_acc_n = 32'd0;
        dd_cnt_n = 3'd4;
      end else begin
        dd_acc_n = {27'd0, byte_i[4:0]};
        dd_cnt_n = 3'd3;
      end
    end else begin
      dd_acc_n = {dd_acc_q[23:0], byte_i};
      dd_cnt_n = dd_cnt_q - 3'd1;
      dd_val   = dd_acc_n;
      dd_done  = (dd_cnt_q == 3'd1);
    end
  end

  always_comb begin
    phase_d   = phase_q;
    hdr_cnt_d = hdr_cnt_q;
    plen_d    = plen_q;
    mtype_d   = mtype_q;
    dd_cnt_d  = dd_cnt_q;
    dd_acc_d  = dd_acc_q;
    sts_d     = sts_q;
    fns_d     = fns_q;
    dlen_d    = dlen_q;
    err_d     = err_q;
    type_ok   = 1'b0;
    fin       = 1'b0;
    have_tok  = 1'b0;
    tok       = '0;
    end_tok   = '0;
    oc        = mrsp_pkg::OC_OK;
    after_sts = (mtype_q == mrsp_pkg::TYPE_PULL) ? mrsp_pkg::PH_FNCOUNT : mrsp_pkg::PH_SKIP;

    if (byte_fire_i) begin
      if (phase_q == mrsp_pkg::PH_HEADER) begin
        if (hdr_cnt_q != mrsp_pkg::HDR_LEN_BYTES) begin
          plen_d    = {plen_q[23:0], byte_i};
          hdr_cnt_d = hdr_cnt_q + 3'd1;
        end else begin
          mtype_d   = byte_i;
          hdr_cnt_d = 3'd0;
          dd_cnt_d  = 3'd0;
          dd_acc_d  = 32'd0;
          unique case (kind_q)
            mrsp_pkg::RK_HELLO: type_ok = (byte_i == mrsp_pkg::TYPE_HELLO_A) ||
                                          (byte_i == mrsp_pkg::TYPE_HELLO_B);
            mrsp_pkg::RK_PUSH:  type_ok = (byte_i == mrsp_pkg::TYPE_PUSH);
            mrsp_pkg::RK_PULL:  type_ok = (byte_i == mrsp_pkg::TYPE_PULL);
            default:            type_ok = 1'b0;
          endcase
          if (!type_ok) begin
            err_d   = mrsp_pkg::OC_BAD_TYPE;
            phase_d = mrsp_pkg::PH_SKIP;
          end else begin
            err_d   = mrsp_pkg::OC_OK;
            phase_d = (kind_q == mrsp_pkg::RK_HELLO) ? mrsp_pkg::PH_SKIP
                                                     : mrsp_pkg::PH_STCOUNT;
          end
          fin = (plen_q == 32'd0);
        end
      end else begin
        if (plen_q != 32'd0) begin
          plen_d = plen_q - 32'd1;
        end
        fin = (plen_q == 32'd0) || (plen_q == 32'd1);
        tok.value = dd_val;

        case (phase_q)
          mrsp_pkg::PH_STCOUNT: begin
            dd_cnt_d = dd_cnt_n;
            dd_acc_d = dd_acc_n;
            if (dd_done) begin
              have_tok = 1'b1;
              tok.kind = mrsp_pkg::TK_ST_COUNT;
              sts_d    = dd_val;
              phase_d  = (dd_val == 32'd0) ? after_sts : mrsp_pkg::PH_STATUS;
            end
          end
          mrsp_pkg::PH_STATUS: begin
            dd_cnt_d = dd_cnt_n;
            dd_acc_d = dd_acc_n;
            if (dd_done) begin
              have_tok = 1'b1;
              tok.kind = mrsp_pkg::TK_STATUS;
              sts_d    = sts_q - 32'd1;
              if (sts_q == 32'd1) begin
                phase_d = after_sts;
              end
            end
          end
          mrsp_pkg::PH_FNCOUNT: begin
            dd_cnt_d = dd_cnt_n;
            dd_acc_d = dd_acc_n;
            if (dd_done) begin
              have_tok = 1'b1;
              tok.kind = mrsp_pkg::TK_FN_COUNT;
              fns_d    = dd_val;
              phase_d  = (dd_val == 32'd0) ? mrsp_pkg::PH_SKIP : mrsp_pkg::PH_NAME;
            end
          end
          mrsp_pkg::PH_NAME: begin
            have_tok = 1'b1;
            if (byte_i == 8'd0) begin
              tok.kind  = mrsp_pkg::TK_NAME_END;
              tok.value = 32'd0;
              phase_d   = mrsp_pkg::PH_FLEN;
            end else begin
              tok.kind  = mrsp_pkg::TK_NAME;
              tok.value = {24'd0, byte_i};
            end
          end
          mrsp_pkg::PH_FLEN: begin
            dd_cnt_d = dd_cnt_n;
            dd_acc_d = dd_acc_n;
            if (dd_done) begin
              have_tok = 1'b1;
              tok.kind = mrsp_pkg::TK_FN_LEN;
              phase_d  = mrsp_pkg::PH_DLEN;
            end
          end
          mrsp_pkg::PH_DLEN: begin
            dd_cnt_d = dd_cnt_n;
            dd_acc_d = dd_acc_n;
            if (dd_done) begin
              have_tok = 1'b1;
              tok.kind = mrsp_pkg::TK_DATA_LEN;
              dlen_d   = dd_val;
              phase_d  = (dd_val == 32'd0) ? mrsp_pkg::PH_POP : mrsp_pkg::PH_DATA;
            end
          end
          mrsp_pkg::PH_DATA: begin
            have_tok  = 1'b1;
            tok.kind  = mrsp_pkg::TK_DATA;
            tok.value = {24'd0, byte_i};
            dlen_d    = dlen_q - 32'd1;
            if (dlen_q == 32'd1) begin
              phase_d = mrsp_pkg::PH_POP;
            end
          end
          mrsp_pkg::PH_POP: begin
            dd_cnt_d = dd_cnt_n;
            dd_acc_d = dd_acc_n;
            if (dd_done) begin
              have_tok = 1'b1;
              tok.kind = mrsp_pkg::TK_POP;
              fns_d    = fns_q - 32'd1;
              phase_d  = (fns_q == 32'd1) ? mrsp_pkg::PH_SKIP : mrsp_pkg::PH_NAME;
            end
          end
          default: ;
        endcase
      end

      if (fin) begin
        oc = err_d;
        if ((err_d == mrsp_pkg::OC_OK) && (phase_d != mrsp_pkg::PH_SKIP)) begin
          oc = mrsp_pkg::OC_TRUNC;
        end
        end_tok.kind    = mrsp_pkg::TK_END;
        end_tok.value   = {24'd0, mtype_d};
        end_tok.outcome = oc;
        end_tok.last    = 1'b1;
        phase_d   = mrsp_pkg::PH_HEADER;
        hdr_cnt_d = 3'd0;
        err_d     = mrsp_pkg::OC_OK;
        dd_cnt_d  = 3'd0;
        dd_acc_d  = 32'd0;
      end
    end
  end

  // The end token always comes last; a field token is last only when alone.
  always_comb begin
    res_o = '0;
    if (have_tok && fin) begin
      res_o.count = 2'd2;
      res_o.tok0  = tok;
      res_o.tok1  = end_tok;
    end else if (have_tok) begin
      res_o.count     = 2'd1;
      res_o.tok0      = tok;
      res_o.tok0.last = 1'b1;
    end else if (fin) begin
      res_o.count = 2'd1;
      res_o.tok0  = end_tok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= mrsp_pkg::PH_HEADER;
      hdr_cnt_q <= 3'd0;
      plen_q    <= 32'd0;
      mtype_q   <= 8'd0;
      dd_cnt_q  <= 3'd0;
      dd_acc_q  <= 32'd0;
      sts_q     <= 32'd0;
      fns_q     <= 32'd0;
      dlen_q    <= 32'd0;
      err_q     <= mrsp_pkg::OC_OK;
    end else begin
      phase_q   <= phase_d;
      hdr_cnt_q <= hdr_cnt_d;
      plen_q    <= plen_d;
      mtype_q   <= mtype_d;
      dd_cnt_q  <= dd_cnt_d;
      dd_acc_q  <= dd_acc_d;
      sts_q     <= sts_d;
      fns_q     <= fns_d;
      dlen_q    <= dlen_d;
      err_q     <= err_d;
    end
  end

endmodule

/* rtl/mrsp_out_fifo.sv */
// ----------------------------------------------------------------------------
// mrsp_out_fifo: result queue
// Takes up to two tokens a cycle from the parser and, while pop_i is high,
// gives one a cycle to the output. Reports room for two more to the input.
// ----------------------------------------------------------------------------
module mrsp_out_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mrsp_pkg::res_t res_i,
  input  logic           pop_i,
  output logic           room_o,
  output logic           valid_o,
  output mrsp_pkg::tok_t tok_o
);

  localparam int unsigned CW = mrsp_pkg::OUT_AW + 1;

  mrsp_pkg::tok_t               mem_q [mrsp_pkg::OUT_DEPTH];
  logic [mrsp_pkg::OUT_AW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [mrsp_pkg::OUT_AW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]                count_q, count_d;
  logic [mrsp_pkg::OUT_AW-1:0]  wr_ptr_p1;
  logic                         pop;

  assign wr_ptr_p1 = wr_ptr_q + 1'b1;
  assign valid_o   = (count_q != '0);
  assign tok_o     = mem_q[rd_ptr_q];
  assign pop       = pop_i && valid_o;
  assign room_o    = (count_q <= CW'(mrsp_pkg::OUT_DEPTH - 2));

  always_comb begin
    wr_ptr_d = wr_ptr_q + mrsp_pkg::OUT_AW'(res_i.count);
    rd_ptr_d = rd_ptr_q + mrsp_pkg::OUT_AW'(pop);
    count_d  = count_q + CW'(res_i.count) - CW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (res_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= res_i.tok0;
    end
    if (res_i.count == 2'd2) begin
      mem_q[wr_ptr_p1] <= res_i.tok1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

/* rtl/metadata_reply_stream_parser.sv */
// ----------------------------------------------------------------------------
// metadata_reply_stream_parser: top level of the reply byte parser
// Parses the 5-byte header and the packed-integer payload of a reply and
// emits every decoded field as a token, closed by a message end token.
// ----------------------------------------------------------------------------
// Usage. Reply bytes enter one per request on the s_axis channel, header
// first (four big-endian length bytes, then the type byte), then the payload.
// Tokens leave on the m_axis channel: tuser carries the token kind, tdata the
// value and, for the message end token, the outcome; tlast marks the final
// token caused by one input byte. A byte yields no token, one token, or a
// field token followed by the message end token.
// The user sets the expected reply kind through cfg_we_i and cfg_wdata_i only
// while the block is idle (not enforced by the block); it is sampled on each type byte.
// Throughput is one byte per cycle while the result queue has room. The
// tokens of an accepted byte are written into a four-entry result queue
// and shown on m_axis from it in order, and s_axis_tready stays high while
// that queue has room for two more tokens, so a stalled receiver stops the
// input after the queue fills; the queue's single read port gives one token
// per cycle while m_axis_tready is high, so a byte's two tokens leave in turn.
// Reset clears the parser to the start of a header, empties the queue and
// sets the expected reply kind to pull.
// ----------------------------------------------------------------------------
module metadata_reply_stream_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration: expected reply kind.
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_wdata_i,
  // Input bytes.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [7:0] data_byte
  // Result tokens.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [mrsp_pkg::TDATA_W-1:0]  m_axis_tdata,   // [31:0] value, [33:32] outcome,
                                                        // upper bits zero
  output logic [3:0]                    m_axis_tuser,   // [3:0] token_kind
  output logic                          m_axis_tlast    // last_of_item
);

  logic           byte_fire;
  logic           room;
  mrsp_pkg::res_t res;
  mrsp_pkg::tok_t head;

  // Input is taken whenever the queue can absorb the worst case of one byte.
  assign s_axis_tready = room;
  assign byte_fire     = s_axis_tvalid && room;

  mrsp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .byte_fire_i (byte_fire),
    .byte_i      (s_axis_tdata),
    .res_o       (res)
  );

  mrsp_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .res_i   (res),
    .pop_i   (m_axis_tready),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .tok_o   (head)
  );

  assign m_axis_tdata = {{(mrsp_pkg::TDATA_W - 34){1'b0}}, head.outcome, head.value};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

endmodule

/* rtl/mrsp_checker.sv */
// ----------------------------------------------------------------------------
// mrsp_checker: port-level checks of the reply parser
// Watches the top level's ports and flags token streams that the parser
// can never produce.
// ----------------------------------------------------------------------------
module mrsp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [mrsp_pkg::TDATA_W-1:0]  m_axis_tdata,
  input logic [3:0]                    m_axis_tuser,
  input logic                          m_axis_tlast
);

  // A stalled token stays on show unchanged.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("result token changed while stalled");

  // Only the message end token carries an outcome.
  a_outcome_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != mrsp_pkg::TK_END) |->
      (m_axis_tdata[33:32] == 2'd0))
    else $error("outcome set on a field token");

  // The message end token always closes the tokens of its byte.
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == mrsp_pkg::TK_END) |-> m_axis_tlast)
    else $error("message end token not marked last");

  // A name end token carries a zero value.
  a_name_end_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == mrsp_pkg::TK_NAME_END) |->
      (m_axis_tdata[31:0] == 32'd0))
    else $error("name end token with nonzero value");

endmodule

bind metadata_reply_stream_parser mrsp_checker u_mrsp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

/* tb/sv/metadata_reply_stream_parser_tb.sv */
// ----------------------------------------------------------------------------
// metadata_reply_stream_parser_tb: self-checking bench for the reply parser
// Feeds header and payload bytes of hello, push and pull replies, well formed
// and broken, and checks every token against an independent token predictor.
// ----------------------------------------------------------------------------

// Token predictor and store of expected tokens. note_byte() advances the
// predicted parser by one accepted byte and queues the tokens that byte
// causes; check_token() pops the oldest token and compares it.
class token_scoreboard;
  logic [1:0]       kind_reg;
  mrsp_pkg::phase_e ph;
  logic [2:0]       hdr_cnt;
  logic [31:0]      pay_left;
  logic [7:0]       msg_type;
  logic [2:0]       int_due;
  logic [31:0]      int_acc;
  logic [31:0]      st_left;
  logic [31:0]      fn_left;
  logic [31:0]      blob_left;
  mrsp_pkg::oc_e    err;
  mrsp_pkg::tok_t   tok_buf [2];
  int               tok_n;
  mrsp_pkg::tok_t   expected_q [$];
  int               mismatches;
  int               tokens_checked;

  function new();
    kind_reg       = mrsp_pkg::RK_RESET;
    ph             = mrsp_pkg::PH_HEADER;
    hdr_cnt        = '0;
    pay_left       = '0;
    msg_type       = '0;
    int_due        = '0;
    int_acc        = '0;
    st_left        = '0;
    fn_left        = '0;
    blob_left      = '0;
    err            = mrsp_pkg::OC_OK;
    tok_n          = 0;
    mismatches     = 0;
    tokens_checked = 0;
  endfunction

  function void emit(mrsp_pkg::tk_e k, logic [31:0] v, mrsp_pkg::oc_e oc);
    if (tok_n < 2) begin
      tok_buf[tok_n].kind    = k;
      tok_buf[tok_n].value   = v;
      tok_buf[tok_n].outcome = oc;
      tok_buf[tok_n].last    = 1'b0;
      tok_n++;
    end
  endfunction

  // Packed integer decoder; returns 1 once the value is complete.
  function bit feed_int(logic [7:0] b, output logic [31:0] v);
    v = '0;
    if (int_due == 0) begin
      if (!b[7]) begin
        v = {24'd0, b};
        return 1'b1;
      end
      if (b[7:6] == 2'b10) begin
        int_acc = {26'd0, b[5:0]};
        int_due = 3'd1;
      end else if (b == 8'hff) begin
        int_acc = '0;
        int_due = 3'd4;
      end else begin
        int_acc = {27'd0, b[4:0]};
        int_due = 3'd3;
      end
      return 1'b0;
    end
    int_acc = {int_acc[23:0], b};
    int_due--;
    if (int_due == 0) begin
      v = int_acc;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Only a pull reply carries function records after its statuses.
  function void statuses_done();
    if (msg_type == mrsp_pkg::TYPE_PULL) ph = mrsp_pkg::PH_FNCOUNT;
    else ph = mrsp_pkg::PH_SKIP;
  endfunction

  function void parse_payload(logic [7:0] b);
    logic [31:0] v;
    case (ph)
      mrsp_pkg::PH_STCOUNT: if (feed_int(b, v)) begin
        emit(mrsp_pkg::TK_ST_COUNT, v, mrsp_pkg::OC_OK);
        st_left = v;
        if (v == 0) statuses_done();
        else ph = mrsp_pkg::PH_STATUS;
      end
      mrsp_pkg::PH_STATUS: if (feed_int(b, v)) begin
        emit(mrsp_pkg::TK_STATUS, v, mrsp_pkg::OC_OK);
        st_left--;
        if (st_left == 0) statuses_done();
      end
      mrsp_pkg::PH_FNCOUNT: if (feed_int(b, v)) begin
        emit(mrsp_pkg::TK_FN_COUNT, v, mrsp_pkg::OC_OK);
        fn_left = v;
        if (v == 0) ph = mrsp_pkg::PH_SKIP;
        else ph = mrsp_pkg::PH_NAME;
      end
      mrsp_pkg::PH_NAME: begin
        if (b == 8'h00) begin
          emit(mrsp_pkg::TK_NAME_END, 32'd0, mrsp_pkg::OC_OK);
          ph = mrsp_pkg::PH_FLEN;
        end else begin
          emit(mrsp_pkg::TK_NAME, {24'd0, b}, mrsp_pkg::OC_OK);
        end
      end
      mrsp_pkg::PH_FLEN: if (feed_int(b, v)) begin
        emit(mrsp_pkg::TK_FN_LEN, v, mrsp_pkg::OC_OK);
        ph = mrsp_pkg::PH_DLEN;
      end
      mrsp_pkg::PH_DLEN: if (feed_int(b, v)) begin
        emit(mrsp_pkg::TK_DATA_LEN, v, mrsp_pkg::OC_OK);
        blob_left = v;
        if (v == 0) ph = mrsp_pkg::PH_POP;
        else ph = mrsp_pkg::PH_DATA;
      end
      mrsp_pkg::PH_DATA: begin
        emit(mrsp_pkg::TK_DATA, {24'd0, b}, mrsp_pkg::OC_OK);
        blob_left--;
        if (blob_left == 0) ph = mrsp_pkg::PH_POP;
      end
      mrsp_pkg::PH_POP: if (feed_int(b, v)) begin
        emit(mrsp_pkg::TK_POP, v, mrsp_pkg::OC_OK);
        fn_left--;
        if (fn_left == 0) ph = mrsp_pkg::PH_SKIP;
        else ph = mrsp_pkg::PH_NAME;
      end
      default: ;
    endcase
  endfunction

  // Message end: a body that did not reach the skip phase was cut short.
  function void close_msg();
    mrsp_pkg::oc_e oc;
    oc = err;
    if (err == mrsp_pkg::OC_OK && ph != mrsp_pkg::PH_SKIP) oc = mrsp_pkg::OC_TRUNC;
    emit(mrsp_pkg::TK_END, {24'd0, msg_type}, oc);
    ph      = mrsp_pkg::PH_HEADER;
    hdr_cnt = '0;
    err     = mrsp_pkg::OC_OK;
    int_due = '0;
    int_acc = '0;
  endfunction

  function void note_byte(logic [7:0] b);
    bit type_ok;
    tok_n = 0;
    if (ph == mrsp_pkg::PH_HEADER) begin
      if (hdr_cnt < mrsp_pkg::HDR_LEN_BYTES) begin
        pay_left = {pay_left[23:0], b};
        hdr_cnt++;
        return;
      end
      msg_type = b;
      hdr_cnt  = '0;
      int_due  = '0;
      int_acc  = '0;
      err      = mrsp_pkg::OC_OK;
      case (kind_reg)
        mrsp_pkg::RK_HELLO: type_ok = (b == mrsp_pkg::TYPE_HELLO_A) ||
                                      (b == mrsp_pkg::TYPE_HELLO_B);
        mrsp_pkg::RK_PUSH:  type_ok = (b == mrsp_pkg::TYPE_PUSH);
        mrsp_pkg::RK_PULL:  type_ok = (b == mrsp_pkg::TYPE_PULL);
        default:            type_ok = 1'b0;
      endcase
      if (!type_ok) begin
        err = mrsp_pkg::OC_BAD_TYPE;
        ph  = mrsp_pkg::PH_SKIP;
      end else if (kind_reg == mrsp_pkg::RK_HELLO) begin
        ph = mrsp_pkg::PH_SKIP;
      end else begin
        ph = mrsp_pkg::PH_STCOUNT;
      end
      if (pay_left == 0) close_msg();
    end else begin
      if (pay_left != 0) pay_left--;
      parse_payload(b);
      if (pay_left == 0) close_msg();
    end
    if (tok_n > 0) begin
      tok_buf[tok_n-1].last = 1'b1;
      for (int i = 0; i < tok_n; i++) expected_q.insert(expected_q.size(), tok_buf[i]);
    end
  endfunction

  function void check_token(logic [3:0] kind, logic [mrsp_pkg::TDATA_W-1:0] data,
                            logic last);
    mrsp_pkg::tok_t               e;
    logic [mrsp_pkg::TDATA_W-1:0] want;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected token: kind %0d data %h last %0b", kind, data, last);
      return;
    end
    e    = expected_q.pop_front();
    want = {{(mrsp_pkg::TDATA_W-34){1'b0}}, e.outcome, e.value};
    tokens_checked++;
    if (kind !== e.kind || data !== want || last !== e.last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("token mismatch: expected kind %0d data %h last %0b, %s %0d %s %h %s %0b",
                 e.kind, want, e.last, "got kind", kind, "data", data, "last", last);
    end
  endfunction
endclass

module metadata_reply_stream_parser_tb;

  // Cycles with no accepted request before the run is declared hung. The
  // longest legal quiet stretch is the receiver hold-off below.
  localparam int WATCHDOG_LIMIT = 2000;
  // Margin once every predicted token is delivered, before a register write
  // or the end of the run.
  localparam int DRAIN_PAUSE    = 8;
  localparam int RANDOM_BYTES   = 1150;
  localparam int HOLD_CYCLES    = 400;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [1:0]                   cfg_wdata_i;
  logic                         s_axis_tvalid;
  logic                         s_axis_tready;
  logic [7:0]                   s_axis_tdata;   // [7:0] data_byte
  logic                         m_axis_tvalid;
  logic                         m_axis_tready;
  logic [mrsp_pkg::TDATA_W-1:0] m_axis_tdata;   // [31:0] value, [33:32] outcome,
                                                // upper bits zero
  logic [3:0]                   m_axis_tuser;   // [3:0] token_kind
  logic                         m_axis_tlast;

  token_scoreboard sb;

  // Stimulus bookkeeping.
  logic [7:0] body_q [$];
  logic [1:0] cur_kind;
  bit         src_steady;
  bit         hold_sink;
  int         bytes_sent;
  int         replies_sent;
  int         kind_writes;
  int         replies_by_kind [4];
  int         quiet_cycles;

  metadata_reply_stream_parser i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Appends one byte to the reply body under construction.
  function automatic void add_byte(logic [7:0] b);
    body_q.insert(body_q.size(), b);
  endfunction

  // Idle gap length: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Integer of a random magnitude class, the limits of each form included.
  function automatic logic [31:0] rand_value();
    logic [31:0] lim;
    case ($urandom_range(0, 4))
      0: return 32'($urandom_range(0, 32'h7f));
      1: return 32'($urandom_range(0, 32'h3fff));
      2: return 32'($urandom_range(0, 32'h1fff_ffff));
      3: return 32'($urandom);
      default: begin
        case ($urandom_range(0, 4))
          0: lim = 32'h0000_0000;
          1: lim = 32'h0000_007f;
          2: lim = 32'h0000_3fff;
          3: lim = 32'h1fff_ffff;
          default: lim = 32'hffff_ffff;
        endcase
        return lim;
      end
    endcase
  endfunction

  // Appends v in a packed form: 0 one byte, 1 two, 2 four, 3 five bytes.
  // The four-byte form takes a lead byte of either 110xxxxx or 111xxxxx.
  function automatic void put_int(logic [31:0] v, int form);
    logic [7:0] lead;
    case (form)
      0: add_byte({1'b0, v[6:0]});
      1: begin
        add_byte({2'b10, v[13:8]});
        add_byte(v[7:0]);
      end
      2: begin
        lead = {3'b110, v[28:24]};
        if ($urandom_range(0, 1) == 1 && v[28:24] != 5'h1f) lead[5] = 1'b1;
        add_byte(lead);
        add_byte(v[23:16]);
        add_byte(v[15:8]);
        add_byte(v[7:0]);
      end
      default: begin
        add_byte(8'hff);
        add_byte(v[31:24]);
        add_byte(v[23:16]);
        add_byte(v[15:8]);
        add_byte(v[7:0]);
      end
    endcase
  endfunction

  // Shortest form that holds v, or now and then a longer redundant one.
  function automatic void put_any_int(logic [31:0] v);
    int shortest;
    if (v < 32'h80) shortest = 0;
    else if (v < 32'h4000) shortest = 1;
    else if (v < 32'h2000_0000) shortest = 2;
    else shortest = 3;
    if ($urandom_range(0, 9) < 6) put_int(v, shortest);
    else put_int(v, $urandom_range(shortest, 3));
  endfunction

  // One byte request: optional idle gap, then hold tvalid until accepted.
  // tvalid stays high after acceptance so back-to-back bytes need no toggle.
  task automatic send_byte(input logic [7:0] b);
    int          gap;
    logic [31:0] junk;
    gap = src_steady ? 0 : pick_gap();
    if (gap > 0) begin
      junk = $urandom;
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= junk[7:0];
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  // The register is only written with the block idle: input stopped, every
  // predicted token delivered, and a short pause for any byte still inside.
  task automatic write_kind(input logic [1:0] v);
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_PAUSE) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.kind_reg = v;
    cur_kind    = v;
    kind_writes++;
  endtask

  // Sends header and payload from body_q. len_mode 0 sends the body as is,
  // 1 appends trailing bytes, 2 cuts the payload short. With mid_write the
  // register changes between the type byte and the payload.
  task automatic send_reply(input logic [7:0] ty, input int len_mode,
                            input bit mid_write, input logic [1:0] mid_kind);
    int          len;
    logic [31:0] lenw;
    logic [31:0] junk;
    if (len_mode == 1) begin
      repeat ($urandom_range(1, 4)) begin
        junk = $urandom;
        add_byte(junk[7:0]);
      end
    end
    len = body_q.size();
    if (len_mode == 2 && len > 0) len = $urandom_range(0, len - 1);
    lenw = 32'(len);
    replies_by_kind[cur_kind]++;
    send_byte(lenw[31:24]);
    send_byte(lenw[23:16]);
    send_byte(lenw[15:8]);
    send_byte(lenw[7:0]);
    send_byte(ty);
    if (mid_write) write_kind(mid_kind);
    for (int i = 0; i < len; i++) send_byte(body_q[i]);
    replies_sent++;
  endtask

  // One random reply for the current register setting. Most are well formed
  // bodies of random content; the rest carry a random type byte or a payload
  // of raw noise, and some are cut short or padded.
  task automatic random_reply();
    int          r;
    int          n;
    int          nf;
    int          m;
    int          len_mode;
    logic [7:0]  ty;
    logic [31:0] junk;
    r          = $urandom_range(0, 99);
    src_steady = ($urandom_range(0, 3) == 0);
    body_q.delete();
    case (cur_kind)
      mrsp_pkg::RK_HELLO: ty = ($urandom_range(0, 1) == 1) ? mrsp_pkg::TYPE_HELLO_A
                                                           : mrsp_pkg::TYPE_HELLO_B;
      mrsp_pkg::RK_PUSH:  ty = mrsp_pkg::TYPE_PUSH;
      mrsp_pkg::RK_PULL:  ty = mrsp_pkg::TYPE_PULL;
      default: begin
        case ($urandom_range(0, 3))
          0: ty = mrsp_pkg::TYPE_HELLO_A;
          1: ty = mrsp_pkg::TYPE_HELLO_B;
          2: ty = mrsp_pkg::TYPE_PUSH;
          default: ty = mrsp_pkg::TYPE_PULL;
        endcase
      end
    endcase
    if (r < 10) begin
      junk = $urandom;
      ty   = junk[7:0];
    end
    if (r >= 10 && r < 20) begin
      n = $urandom_range(0, 12);
      repeat (n) begin
        junk = $urandom;
        add_byte(junk[7:0]);
      end
    end else if (ty == mrsp_pkg::TYPE_PUSH || ty == mrsp_pkg::TYPE_PULL) begin
      n = $urandom_range(0, 3);
      put_any_int(32'(n));
      repeat (n) put_any_int(rand_value());
      if (ty == mrsp_pkg::TYPE_PULL) begin
        nf = $urandom_range(0, 3);
        put_any_int(32'(nf));
        repeat (nf) begin
          n = $urandom_range(0, 5);
          repeat (n) add_byte(8'($urandom_range(1, 255)));
          add_byte(8'h00);
          put_any_int(rand_value());
          n = $urandom_range(0, 5);
          put_any_int(32'(n));
          repeat (n) add_byte(8'($urandom_range(0, 255)));
          put_any_int(rand_value());
        end
      end
    end else begin
      n = $urandom_range(0, 6);
      repeat (n) begin
        junk = $urandom;
        add_byte(junk[7:0]);
      end
    end
    m = $urandom_range(0, 99);
    if (m < 70) len_mode = 0;
    else if (m < 85) len_mode = 1;
    else len_mode = 2;
    send_reply(ty, len_mode, ($urandom_range(0, 19) == 0), 2'($urandom_range(0, 3)));
  endtask

  // Receiver: random ready bursts and gaps. On request from the main flow it
  // holds tready low for a long stretch so the result queue fills and the
  // block stops taking input while the sender keeps offering bytes.
  initial begin : sink
    int run;
    int gap;
    m_axis_tready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_sink) begin
        hold_sink = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      if ($urandom_range(0, 9) == 0) run = $urandom_range(50, 150);
      else run = $urandom_range(1, 20);
      m_axis_tready <= 1'b1;
      repeat (run) @(posedge clk_i);
      gap = pick_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  // Result check and watchdog. Both sample the pre-edge values of the
  // handshake signals, so nothing depends on the order of processes.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_token(m_axis_tuser, m_axis_tdata, m_axis_tlast);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no request accepted for %0d cycles", quiet_cycles);
        $display("simulation failed");
        $finish;
      end else begin
        quiet_cycles++;
      end
    end
  end

  initial begin : main
    int  phase_no;
    int  phase_end;
    int  hold_at;
    bit  hold_done;
    int  r;
    sb            = new();
    cur_kind      = mrsp_pkg::RK_RESET;
    src_steady    = 1'b0;
    hold_sink     = 1'b0;
    bytes_sent    = 0;
    replies_sent  = 0;
    kind_writes   = 0;
    quiet_cycles  = 0;
    for (int i = 0; i < 4; i++) replies_by_kind[i] = 0;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= mrsp_pkg::RK_RESET;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'h00;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed replies. Empty pull reply under the reset setting: the end
    // token comes on the type byte and reports a truncated body.
    body_q.delete();
    send_reply(mrsp_pkg::TYPE_PULL, 0, 1'b0, mrsp_pkg::RK_PULL);
    // Pull reply with no statuses and one function: name byte 0xff, a
    // two-byte length at its limit, one zero data byte, a popularity in the
    // four-byte form with a 111xxxxx lead, then one trailing byte.
    body_q = '{8'h00, 8'h01, 8'hff, 8'h00, 8'hbf, 8'hff, 8'h01, 8'h00,
               8'he0, 8'h00, 8'h00, 8'h01, 8'h55};
    send_reply(mrsp_pkg::TYPE_PULL, 0, 1'b0, mrsp_pkg::RK_PULL);
    // Push reply whose five-byte status count is cut off; the register is
    // rewritten to the invalid setting after the type byte, which must not
    // change how the body is parsed.
    write_kind(mrsp_pkg::RK_PUSH);
    body_q = '{8'hff, 8'hff, 8'hff};
    send_reply(mrsp_pkg::TYPE_PUSH, 0, 1'b1, 2'd3);
    // Invalid setting: no type matches, the payload is thrown away.
    body_q = '{8'h7f};
    send_reply(mrsp_pkg::TYPE_HELLO_A, 0, 1'b0, 2'd3);
    // Empty hello reply is fine.
    write_kind(mrsp_pkg::RK_HELLO);
    body_q.delete();
    send_reply(mrsp_pkg::TYPE_HELLO_B, 0, 1'b0, mrsp_pkg::RK_HELLO);

    // Random phases: each starts with a register write, the first four walk
    // through every setting, later ones favor pull replies.
    phase_no  = 0;
    hold_done = 1'b0;
    hold_at   = bytes_sent + 200;
    phase_end = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      if (phase_no < 4) begin
        write_kind(2'(phase_no));
      end else begin
        r = $urandom_range(0, 9);
        if (r < 5) write_kind(mrsp_pkg::RK_PULL);
        else if (r < 7) write_kind(mrsp_pkg::RK_PUSH);
        else if (r < 9) write_kind(mrsp_pkg::RK_HELLO);
        else write_kind(2'd3);
      end
      phase_no++;
      phase_end = bytes_sent + $urandom_range(60, 140);
      while (bytes_sent < phase_end && bytes_sent < RANDOM_BYTES) begin
        if (!hold_done && bytes_sent >= hold_at) begin
          hold_sink = 1'b1;
          hold_done = 1'b1;
        end
        random_reply();
      end
    end

    // Drain: stop offering, wait for every predicted token, then a margin
    // in which no stray token may appear.
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (2 * DRAIN_PAUSE) @(posedge clk_i);

    $display("Covered %0d bytes in %0d replies, %0d tokens checked, %0d register writes.",
             bytes_sent, replies_sent, sb.tokens_checked, kind_writes);
    $display("Replies per setting: hello %0d, push %0d, pull %0d, invalid %0d; mismatches %0d.",
             replies_by_kind[0], replies_by_kind[1], replies_by_kind[2], replies_by_kind[3],
             sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
